// ----- src/dltq_pkg.sv -----
// shared types, codes and controller/datapath interface for the delta list timer queue
package dltq_pkg;

  // request operation codes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // response event codes
  localparam logic [1:0] EV_SET_OK    = 2'd0;
  localparam logic [1:0] EV_SET_FULL  = 2'd1;
  localparam logic [1:0] EV_EXPIRED   = 2'd2;
  localparam logic [1:0] EV_TICK_IDLE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [7:0]  timer_id;
    logic [15:0] duration;
  } req_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  expired_id;
    logic [15:0] head_remaining;
    logic        list_empty;
    logic        last;
  } rsp_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_WALK,
    CMD_SHIFT_RD,
    CMD_SHIFT,
    CMD_INSERT,
    CMD_SCAN,
    CMD_EMIT_RD,
    CMD_EMIT_LD
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] ev;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic head_due;
    logic walk_adv;
    logic walk_end;
    logic shift_last;
    logic scan_more;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/dltq_datapath.sv -----
// datapath: circular entry memories, walk/shift/scan counters and response register
module dltq_datapath #(
  parameter int MAX_TIMERS = 16,
  parameter int TIME_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dltq_pkg::req_t     req,
  input  dltq_pkg::ctl_cmd_t cmd,
  output dltq_pkg::dp_status_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output dltq_pkg::rsp_t     rsp
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int SW = CW + 1;
  localparam int TW = TIME_BITS;
  localparam logic [32:0] TMAX = (33'd1 << TIME_BITS) - 33'd1;

  // logical position to physical memory address, wrapping at the depth
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [CW-1:0] lidx);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(lidx);
    if (sum >= SW'(MAX_TIMERS)) sum = sum - SW'(MAX_TIMERS);
    return IW'(sum);
  endfunction

  logic [7:0]    ids    [MAX_TIMERS];
  logic [TW-1:0] deltas [MAX_TIMERS];

  logic [CW-1:0] count;
  logic [IW-1:0] head;
  logic [IW-1:0] base;
  logic [TW-1:0] head_delta;
  logic [TW-1:0] rem;
  logic [7:0]    new_id;
  logic [CW-1:0] pos;
  logic [CW-1:0] shift_idx;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] emit_idx;
  logic [CW-1:0] emit_cnt;
  logic [7:0]    rd_id;
  logic [TW-1:0] rd_delta;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_id_en;
  logic          wr_delta_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_id;
  logic [TW-1:0] wr_delta;
  logic [TW-1:0] dur_sat;
  logic          tick_dec;

  assign dur_sat = (33'(req.duration) > TMAX) ? TW'(TMAX) : TW'(req.duration);

  always_comb begin
    stat.full       = (count == CW'(MAX_TIMERS));
    stat.empty      = (count == '0);
    stat.head_due   = (head_delta < TW'(2));
    stat.walk_end   = (pos == count);
    stat.walk_adv   = (pos != count) && (rem >= rd_delta);
    stat.shift_last = (shift_idx == pos);
    stat.scan_more  = (scan_idx != count) && (rd_delta == '0);
    stat.emit_last  = (CW'(emit_idx + 1'b1) == emit_cnt);
    stat.out_free   = !rsp_valid || rsp_ready;
  end

  assign tick_dec = (req.op == dltq_pkg::OP_TICK) && !stat.empty && !stat.head_due;

  // memory port control
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = head;
    wr_id_en    = 1'b0;
    wr_delta_en = 1'b0;
    wr_addr     = head;
    wr_id       = rd_id;
    wr_delta    = rd_delta;
    case (cmd.op)
      dltq_pkg::CMD_ACCEPT: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, (req.op == dltq_pkg::OP_SET) ? CW'(0) : CW'(1));
        if (tick_dec) begin
          wr_delta_en = 1'b1;
          wr_delta    = head_delta - TW'(1);
        end
      end
      dltq_pkg::CMD_WALK: begin
        if (stat.walk_adv) begin
          rd_en   = 1'b1;
          rd_addr = phys(head, CW'(pos + 1'b1));
        end
      end
      dltq_pkg::CMD_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, CW'(count - 1'b1));
      end
      dltq_pkg::CMD_SHIFT: begin
        wr_id_en    = 1'b1;
        wr_delta_en = 1'b1;
        wr_addr     = phys(head, CW'(shift_idx + 1'b1));
        // successor of the new entry loses the new entry's delta
        wr_delta    = stat.shift_last ? (rd_delta - rem) : rd_delta;
        if (!stat.shift_last) begin
          rd_en   = 1'b1;
          rd_addr = phys(head, CW'(shift_idx - 1'b1));
        end
      end
      dltq_pkg::CMD_INSERT: begin
        wr_id_en    = 1'b1;
        wr_delta_en = 1'b1;
        wr_addr     = phys(head, pos);
        wr_id       = new_id;
        wr_delta    = rem;
      end
      dltq_pkg::CMD_SCAN: begin
        if (stat.scan_more) begin
          rd_en   = 1'b1;
          rd_addr = phys(head, CW'(scan_idx + 1'b1));
        end
      end
      dltq_pkg::CMD_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(base, emit_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_id_en) ids[wr_addr] <= wr_id;
    if (wr_delta_en) deltas[wr_addr] <= wr_delta;
    if (rd_en) begin
      rd_id    <= ids[rd_addr];
      rd_delta <= deltas[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a new load keeps the register full even when the old transaction leaves
      if (cmd.op == dltq_pkg::CMD_EMIT_LD) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (cmd.op)
        dltq_pkg::CMD_INSERT: count <= CW'(count + 1'b1);
        dltq_pkg::CMD_SCAN: begin
          if (!stat.scan_more) begin
            head  <= phys(head, scan_idx);
            count <= count - scan_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and response payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      dltq_pkg::CMD_ACCEPT: begin
        new_id   <= req.timer_id;
        rem      <= dur_sat;
        pos      <= '0;
        scan_idx <= CW'(1);
        emit_idx <= '0;
        emit_cnt <= CW'(1);
        if (tick_dec) head_delta <= head_delta - TW'(1);
      end
      dltq_pkg::CMD_WALK: begin
        if (stat.walk_adv) begin
          rem <= rem - rd_delta;
          pos <= CW'(pos + 1'b1);
        end
      end
      dltq_pkg::CMD_SHIFT_RD: shift_idx <= CW'(count - 1'b1);
      dltq_pkg::CMD_SHIFT: begin
        if (!stat.shift_last) shift_idx <= CW'(shift_idx - 1'b1);
      end
      dltq_pkg::CMD_INSERT: begin
        if (pos == '0) head_delta <= rem;
      end
      dltq_pkg::CMD_SCAN: begin
        if (stat.scan_more) begin
          scan_idx <= CW'(scan_idx + 1'b1);
        end else begin
          head_delta <= (scan_idx != count) ? rd_delta : '0;
          base       <= head;
          emit_cnt   <= scan_idx;
          emit_idx   <= '0;
        end
      end
      dltq_pkg::CMD_EMIT_LD: begin
        rsp.event_res      <= cmd.ev;
        rsp.expired_id     <= (cmd.ev == dltq_pkg::EV_EXPIRED) ? rd_id : 8'd0;
        rsp.head_remaining <= (count != '0) ? 16'(head_delta) : 16'd0;
        rsp.list_empty     <= (count == '0);
        rsp.last           <= (cmd.ev != dltq_pkg::EV_EXPIRED) || stat.emit_last;
        emit_idx           <= CW'(emit_idx + 1'b1);
      end
      default: ;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == dltq_pkg::CMD_EMIT_LD) |-> (!rsp_valid || rsp_ready))
    else $error("response loaded over an untaken transaction");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TIMERS))
    else $error("pending count above capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == dltq_pkg::CMD_INSERT) |-> !stat.full)
    else $error("insert into a full list");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == dltq_pkg::CMD_SCAN) |-> (scan_idx <= count && scan_idx != '0))
    else $error("expiry scan outside the list");

endmodule

// ----- src/dltq_ctrl.sv -----
// controller state machine sequencing set, tick and response phases
module dltq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_op,
  output logic                 req_ready,
  input  dltq_pkg::dp_status_t stat,
  output dltq_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT_RD,
    S_SHIFT,
    S_INSERT,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t     state, state_next;
  logic [1:0] ev, ev_next;

  always_comb begin
    state_next = state;
    ev_next    = ev;
    cmd.op     = dltq_pkg::CMD_NONE;
    cmd.ev     = ev;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = dltq_pkg::CMD_ACCEPT;
          if (req_op == dltq_pkg::OP_SET) begin
            if (stat.full) begin
              ev_next    = dltq_pkg::EV_SET_FULL;
              state_next = S_EMIT_LD;
            end else begin
              state_next = S_WALK;
            end
          end else if (stat.empty || !stat.head_due) begin
            ev_next    = dltq_pkg::EV_TICK_IDLE;
            state_next = S_EMIT_LD;
          end else begin
            ev_next    = dltq_pkg::EV_EXPIRED;
            state_next = S_SCAN;
          end
        end
      end
      S_WALK: begin
        cmd.op = dltq_pkg::CMD_WALK;
        if (stat.walk_end) state_next = S_INSERT;
        else if (!stat.walk_adv) state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        cmd.op     = dltq_pkg::CMD_SHIFT_RD;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op = dltq_pkg::CMD_SHIFT;
        if (stat.shift_last) state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.op     = dltq_pkg::CMD_INSERT;
        ev_next    = dltq_pkg::EV_SET_OK;
        state_next = S_EMIT_LD;
      end
      S_SCAN: begin
        cmd.op = dltq_pkg::CMD_SCAN;
        if (!stat.scan_more) state_next = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.op     = dltq_pkg::CMD_EMIT_RD;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.op = dltq_pkg::CMD_EMIT_LD;
          if (ev == dltq_pkg::EV_EXPIRED && !stat.emit_last) state_next = S_EMIT_RD;
          else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ev        <= dltq_pkg::EV_SET_OK;
      req_ready <= 1'b1;
    end else begin
      state     <= state_next;
      ev        <= ev_next;
      req_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ----- src/delta_list_timer_queue.sv -----
// top level of the delta list timer queue: controller plus datapath
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  req     | in        | req_valid / req_ready | op, timer_id, duration
//  rsp     | out       | rsp_valid / rsp_ready | event_res, expired_id, head_remaining,
//          |           |                       | list_empty, last
//
//  one request at a time; walk, shift and expiry scan use one read port, one entry a cycle
//  set: walk to the insert position, shift the later entries up unless appended, then insert
//  set on a full list and tick without expiry go straight to the response; expiring tick scans
//  then emits one response per expired timer; reset clears the pending count and head pointer
//  entries need no clearing; a stalled response holds the next load; a new request is taken once the last is loaded
module delta_list_timer_queue #(
  parameter int MAX_TIMERS = 16,
  parameter int TIME_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dltq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dltq_pkg::rsp_t rsp
);

  // command and status between controller and datapath
  dltq_pkg::ctl_cmd_t   cmd;
  dltq_pkg::dp_status_t stat;

  // sequencing: accept, walk/shift/insert for a set, scan/emit for an expiring tick
  dltq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entries live in a circular buffer so expiry only advances the head pointer
  dltq_datapath #(
    .MAX_TIMERS (MAX_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
